[rtl/ofsp_pkg.sv]
// Package for the object file section parser: field widths, header words
// and section kind codes. No dependencies; imported by the interfaces and the top level.
`default_nettype none

package ofsp_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int ADDR_W  = 16;
    localparam int KIND_W  = 2;
    // Body byte counter: a word count doubled needs one bit more than a word
    localparam int COUNT_W = WORD_W + 1;

    localparam logic [WORD_W-1:0] HDR_CODE   = 16'hCADE;
    localparam logic [WORD_W-1:0] HDR_DATA   = 16'hDADA;
    localparam logic [WORD_W-1:0] HDR_SYMBOL = 16'hC3B7;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_CODE   = 2'd0;
    localparam t_kind KIND_DATA   = 2'd1;
    localparam t_kind KIND_SYMBOL = 2'd2;

endpackage : ofsp_pkg

`default_nettype wire

[rtl/ofsp_if.sv]
// Valid/ready channel interfaces of the object file section parser:
// the byte input channel and the result channel. Depends on ofsp_pkg.
`default_nettype none

interface ofsp_byte_if
    import ofsp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] file_byte;

    modport source (output valid, output file_byte, input ready);
    modport sink   (input valid, input file_byte, output ready);
endinterface : ofsp_byte_if

interface ofsp_result_if
    import ofsp_pkg::*;
();
    logic              valid;
    logic              ready;
    t_kind             section_kind;
    logic [ADDR_W-1:0] target_address;
    logic [WORD_W-1:0] payload;
    logic              label_end;

    modport source (output valid, output section_kind, output target_address,
                    output payload, output label_end, input ready);
    modport sink   (input valid, input section_kind, input target_address,
                    input payload, input label_end, output ready);
endinterface : ofsp_result_if

`default_nettype wire

[rtl/object_file_section_parser_top.sv]
// Object file section parser top level: byte stream in, code/data words and
// label characters out. Depends on ofsp_pkg and the interfaces in ofsp_if.sv.
`default_nettype none

// The parser takes one byte of an object file per clock and reads it as
// big-endian 16-bit words. A code (CADE) or data (DADA) header is followed
// by a load address, a word count and the words, each delivered with its
// address; a symbol (C3B7) header is followed by an address, a byte count
// and the label characters, each delivered with that address and the last
// one flagged by label_end. Unknown words outside a section are skipped.
// Every byte is parsed in the cycle it is accepted and any result lands in
// a single result register, valid from the following cycle, so the block
// sustains one byte per clock. The input is held off only while a result
// sits in that register and the result channel is not ready; a byte that
// completes no result is still taken in that case only once the register
// drains, since ready follows the result register alone.
module object_file_section_parser_top
    import ofsp_pkg::*;
(
    input  wire           i_clk,
    input  wire           i_rst_n,
    ofsp_byte_if.sink     i_byte,
    ofsp_result_if.source o_result
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_ADDRESS,
        PH_COUNT,
        PH_BODY
    } t_phase;

    t_phase             r_phase,   n_phase;
    t_kind              r_section, n_section;
    logic [ADDR_W-1:0]  r_addr,    n_addr;
    logic [COUNT_W-1:0] r_count,   n_count;
    logic [BYTE_W-1:0]  r_hold,    n_hold;
    logic               r_parity,  n_parity;

    logic               r_out_valid;
    t_kind              r_out_kind,  n_out_kind;
    logic [ADDR_W-1:0]  r_out_addr,  n_out_addr;
    logic [WORD_W-1:0]  r_out_data,  n_out_data;
    logic               r_out_end,   n_out_end;

    logic               emit;
    logic               accept;
    logic [WORD_W-1:0]  word;
    logic [COUNT_W-1:0] count_dec1;
    logic [COUNT_W-1:0] count_dec2;
    logic [COUNT_W-1:0] count_load;

    assign i_byte.ready = !r_out_valid || o_result.ready;
    assign accept       = i_byte.valid && i_byte.ready;

    assign word       = {r_hold, i_byte.file_byte};
    assign count_dec1 = r_count - COUNT_W'(1);
    assign count_dec2 = r_count - COUNT_W'(2);
    // Symbols count bytes; code and data count words, held here as bytes
    assign count_load = (r_section == KIND_SYMBOL) ? {1'b0, word} : {word, 1'b0};

    always_comb begin
        n_phase    = r_phase;
        n_section  = r_section;
        n_addr     = r_addr;
        n_count    = r_count;
        n_hold     = r_hold;
        n_parity   = r_parity;
        emit       = 1'b0;
        n_out_kind = r_section;
        n_out_addr = r_addr;
        n_out_data = word;
        n_out_end  = 1'b0;

        if (r_phase == PH_BODY && r_section == KIND_SYMBOL) begin
            // Label characters go out byte by byte
            emit       = 1'b1;
            n_out_kind = KIND_SYMBOL;
            n_out_data = {{(WORD_W-BYTE_W){1'b0}}, i_byte.file_byte};
            n_out_end  = (count_dec1 == '0);
            n_count    = count_dec1;
            if (count_dec1 == '0) begin
                n_phase  = PH_HEADER;
                n_parity = 1'b0;
            end
        end else if (!r_parity) begin
            n_hold   = i_byte.file_byte;
            n_parity = 1'b1;
        end else begin
            n_parity = 1'b0;
            case (r_phase)
                PH_HEADER: begin
                    if (word == HDR_CODE) begin
                        n_section = KIND_CODE;
                        n_phase   = PH_ADDRESS;
                    end else if (word == HDR_DATA) begin
                        n_section = KIND_DATA;
                        n_phase   = PH_ADDRESS;
                    end else if (word == HDR_SYMBOL) begin
                        n_section = KIND_SYMBOL;
                        n_phase   = PH_ADDRESS;
                    end
                end
                PH_ADDRESS: begin
                    n_addr  = word;
                    n_phase = PH_COUNT;
                end
                PH_COUNT: begin
                    n_count = count_load;
                    n_phase = (count_load == '0) ? PH_HEADER : PH_BODY;
                end
                PH_BODY: begin
                    // Code or data word complete
                    emit    = 1'b1;
                    n_addr  = r_addr + ADDR_W'(1);
                    n_count = count_dec2;
                    if (count_dec2 == '0) begin
                        n_phase = PH_HEADER;
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_section   <= KIND_CODE;
            r_addr      <= '0;
            r_count     <= '0;
            r_hold      <= '0;
            r_parity    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase   <= n_phase;
                r_section <= n_section;
                r_addr    <= n_addr;
                r_count   <= n_count;
                r_hold    <= n_hold;
                r_parity  <= n_parity;
            end
            if (accept && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload needs no reset
    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out_kind <= n_out_kind;
            r_out_addr <= n_out_addr;
            r_out_data <= n_out_data;
            r_out_end  <= n_out_end;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.section_kind   = r_out_kind;
    assign o_result.target_address = r_out_addr;
    assign o_result.payload        = r_out_data;
    assign o_result.label_end      = r_out_end;

    a_label_end_symbol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_end |-> r_out_kind == KIND_SYMBOL)
        else $error("label end flagged on a non-symbol item");

    a_body_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BODY |-> r_count != '0)
        else $error("section body entered with nothing left to read");

    a_header_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HEADER |-> r_count == '0)
        else $error("byte count left over outside a section");

    a_word_count_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BODY && r_section != KIND_SYMBOL |-> !r_count[0])
        else $error("odd byte count in a code or data body");

endmodule : object_file_section_parser_top

`default_nettype wire
